>>> sv/rv2q_pkg.sv
// ----------------------------------------------------------------------------
// rv2q_pkg: shared types and constants
// Fixed-point formats, CORDIC angle table and the pipeline token layout.
// ----------------------------------------------------------------------------
package rv2q_pkg;

	localparam int InWidth   = 32;
	localparam int SumWidth  = 66;
	localparam int RootWidth = 33;
	localparam int Steps     = 30;
	localparam int DivBits   = 31;

	localparam logic signed [35:0] OneQ30    = 36'sd1073741824;
	localparam logic signed [35:0] CordGain  = 36'sd652032874;
	localparam logic [33:0]        HalfPiQ30 = 34'd1686629713;

	typedef logic signed [35:0] cord_t;

	// Payload of one input transaction
	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} rv_t;

	// Payload of one result transaction
	typedef struct packed {
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
	} quat_t;

	// Square-root cell token
	typedef struct packed {
		logic              vld;
		logic [SumWidth-1:0] rem;
		logic [RootWidth-1:0] root;
		logic [2:0][31:0]  mag;
		logic [2:0]        neg;
		logic              zero;
	} sq_tok_t;

	// CORDIC cell token
	typedef struct packed {
		logic              vld;
		cord_t             x;
		cord_t             y;
		cord_t             z;
		logic [1:0]        quad;
		logic [31:0]       r;
		logic [2:0][31:0]  mag;
		logic [2:0]        neg;
		logic              zero;
	} cd_tok_t;

	// Division cell token, three lanes share one divisor
	typedef struct packed {
		logic              vld;
		logic [2:0][63:0]  num;
		logic [2:0][31:0]  quo;
		logic [31:0]       r;
		logic [2:0]        neg;
		logic signed [31:0] cosv;
		logic              zero;
	} dv_tok_t;

	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] t;
		t = 36'sd0;
		case (i)
			0: t = 36'sd843314857;  1: t = 36'sd497837829;
			2: t = 36'sd263043837;  3: t = 36'sd133525159;
			4: t = 36'sd67021687;   5: t = 36'sd33543516;
			6: t = 36'sd16775851;   7: t = 36'sd8388437;
			8: t = 36'sd4194283;    9: t = 36'sd2097149;
			default: t = (i < 30) ? (36'sd1 <<< (30 - i)) : 36'sd0;
		endcase
		return t;
	endfunction

endpackage

>>> sv/rv2q_if.sv
// ----------------------------------------------------------------------------
// rv2q_if: valid/ready channel
// Carries one payload per transaction between a source and a sink.
// ----------------------------------------------------------------------------
interface rv2q_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/rv2q_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rv2q_sqrt_cell: one digit of the integer square root
// Decides one root bit per cycle while en is high and hands the token on.
// ----------------------------------------------------------------------------
module rv2q_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [5:0]        bit_idx,
	input  rv2q_pkg::sq_tok_t tok_in,
	output rv2q_pkg::sq_tok_t tok_out
);
	import rv2q_pkg::*;

	logic [SumWidth-1:0] trial;
	sq_tok_t nxt;

	// Try root bit bit_idx: subtract 2*root*2^bit_idx + 4^bit_idx
	always_comb begin
		nxt   = tok_in;
		trial = ({{(SumWidth-RootWidth){1'b0}}, tok_in.root} << (bit_idx + 6'd1))
			| (SumWidth'(1) << {bit_idx, 1'b0});
		if (tok_in.rem >= trial) begin
			nxt.rem  = tok_in.rem - trial;
			nxt.root = tok_in.root | (RootWidth'(1) << bit_idx);
		end
	end

	// Advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= nxt;
		end
	end
endmodule

>>> sv/rv2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// rv2q_cordic_cell: one CORDIC micro-rotation
// Rotates by +-atan(2^-step_idx) and hands the token on.
// ----------------------------------------------------------------------------
module rv2q_cordic_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [4:0]        step_idx,
	input  rv2q_pkg::cd_tok_t tok_in,
	output rv2q_pkg::cd_tok_t tok_out
);
	import rv2q_pkg::*;

	cd_tok_t nxt;

	// Rotate toward zero residual angle
	always_comb begin
		nxt = tok_in;
		if (!tok_in.z[35]) begin
			nxt.x = tok_in.x - (tok_in.y >>> step_idx);
			nxt.y = tok_in.y + (tok_in.x >>> step_idx);
			nxt.z = tok_in.z - atan_q30(int'(step_idx));
		end else begin
			nxt.x = tok_in.x + (tok_in.y >>> step_idx);
			nxt.y = tok_in.y - (tok_in.x >>> step_idx);
			nxt.z = tok_in.z + atan_q30(int'(step_idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= nxt;
		end
	end
endmodule

>>> sv/rv2q_div_cell.sv
// ----------------------------------------------------------------------------
// rv2q_div_cell: one restoring division step on three lanes
// Produces quotient bit bit_idx for each lane against the shared norm.
// ----------------------------------------------------------------------------
module rv2q_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [4:0]        bit_idx,
	input  rv2q_pkg::dv_tok_t tok_in,
	output rv2q_pkg::dv_tok_t tok_out
);
	import rv2q_pkg::*;

	dv_tok_t nxt;
	logic [63:0] dsh;

	// Subtract the shifted divisor where it fits
	always_comb begin
		nxt = tok_in;
		dsh = {32'd0, tok_in.r} << bit_idx;
		for (int l = 0; l < 3; l++) begin
			if (tok_in.num[l] >= dsh) begin
				nxt.num[l] = tok_in.num[l] - dsh;
				nxt.quo[l] = tok_in.quo[l] | (32'd1 << bit_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= nxt;
		end
	end
endmodule

>>> sv/rotation_vector_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_vector_to_quaternion: rotation vector to unit quaternion
// Norm by a chain of root cells, sine/cosine by a chain of CORDIC cells,
// scaling by a chain of divider cells.
// ----------------------------------------------------------------------------
// One vector is accepted every cycle while the chain advances; each vector
// passes through 3 entry/squaring stages, 33 root cells, 2 reduction stages,
// 30 CORDIC cells, 2 fold/multiply stages, 31 divider cells and the output
// register. The whole chain advances together; it stalls only while the
// output register holds an unaccepted result, and the input stays ready as
// long as the output may move. A zero vector gives the identity (0,0,0,1).
// ----------------------------------------------------------------------------
module rotation_vector_to_quaternion (
	input  logic clk,
	input  logic arst_n,
	rv2q_if.sink   rot,
	rv2q_if.source quat
);
	import rv2q_pkg::*;

	logic en;
	logic out_vld_q;
	quat_t out_q;

	// Advance whenever the output register is free or being drained
	assign en        = !out_vld_q || quat.ready;
	assign rot.ready = en;

	// Stage 1: magnitudes
	logic             v_s1;
	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= rot.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1[0] <= rot.data.rot_x[31];
			neg_s1[1] <= rot.data.rot_y[31];
			neg_s1[2] <= rot.data.rot_z[31];
			mag_s1[0] <= rot.data.rot_x[31] ? 32'(-rot.data.rot_x) : rot.data.rot_x;
			mag_s1[1] <= rot.data.rot_y[31] ? 32'(-rot.data.rot_y) : rot.data.rot_y;
			mag_s1[2] <= rot.data.rot_z[31] ? 32'(-rot.data.rot_z) : rot.data.rot_z;
		end
	end

	// Stage 2: squares
	logic             v_s2;
	logic [2:0][63:0] sq_s2;
	logic [2:0][31:0] mag_s2;
	logic [2:0]       neg_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s2[l] <= 64'(mag_s1[l]) * 64'(mag_s1[l]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: sum of squares
	sq_tok_t sq_chain [0:RootWidth];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_chain[0] <= '0;
		end else if (en) begin
			sq_chain[0].vld  <= v_s2;
			sq_chain[0].rem  <= SumWidth'(sq_s2[0]) + SumWidth'(sq_s2[1])
				+ SumWidth'(sq_s2[2]);
			sq_chain[0].root <= '0;
			sq_chain[0].mag  <= mag_s2;
			sq_chain[0].neg  <= neg_s2;
			sq_chain[0].zero <= (mag_s2[0] == 32'd0) && (mag_s2[1] == 32'd0)
				&& (mag_s2[2] == 32'd0);
		end
	end

	// Root cells, most significant bit first
	for (genvar g = 0; g < RootWidth; g++) begin : g_sqrt
		rv2q_sqrt_cell u_cell (
			.clk, .arst_n, .en,
			.bit_idx(6'(RootWidth - 1 - g)),
			.tok_in(sq_chain[g]), .tok_out(sq_chain[g + 1])
		);
	end

	// Reduction stage 1: quadrant estimate k = floor((2r + pi/4) / (pi/2))
	sq_tok_t          sq_end;
	logic [33:0]      h30;
	logic [33:0]      hq;
	logic [3:0]       kest;
	logic             v_s4;
	logic [3:0]       k_s4;
	logic [33:0]      h_s4;
	logic [31:0]      r_s4;
	logic [2:0][31:0] mag_s4;
	logic [2:0]       neg_s4;
	logic             zero_s4;
	assign sq_end = sq_chain[RootWidth];
	assign h30    = {sq_end.root[31:0], 1'b0} + 34'd0;
	assign hq     = h30 + (HalfPiQ30 >> 1);
	// k is at most 5; count the multiples of pi/2 up to hq
	always_comb begin
		kest = 4'd0;
		for (int m = 1; m <= 9; m++) begin
			if (36'(hq) >= 36'(m) * 36'(HalfPiQ30)) kest = 4'(m);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_end.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_s4    <= kest;
			h_s4    <= h30;
			r_s4    <= sq_end.root[31:0];
			mag_s4  <= sq_end.mag;
			neg_s4  <= sq_end.neg;
			zero_s4 <= sq_end.zero;
		end
	end

	// Reduction stage 2: remainder and CORDIC seed
	cd_tok_t cd_chain [0:Steps];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_chain[0] <= '0;
		end else if (en) begin
			cd_chain[0].vld  <= v_s4;
			cd_chain[0].x    <= CordGain;
			cd_chain[0].y    <= '0;
			cd_chain[0].z    <= cord_t'({2'b00, h_s4}) - cord_t'(36'(k_s4) * 36'(HalfPiQ30));
			cd_chain[0].quad <= k_s4[1:0];
			cd_chain[0].r    <= r_s4;
			cd_chain[0].mag  <= mag_s4;
			cd_chain[0].neg  <= neg_s4;
			cd_chain[0].zero <= zero_s4;
		end
	end

	for (genvar g = 0; g < Steps; g++) begin : g_cordic
		rv2q_cordic_cell u_cell (
			.clk, .arst_n, .en,
			.step_idx(5'(g)),
			.tok_in(cd_chain[g]), .tok_out(cd_chain[g + 1])
		);
	end

	// Fold quadrant and saturate
	cd_tok_t cd_end;
	cord_t   sv, cv, svs, cvs;
	assign cd_end = cd_chain[Steps];
	always_comb begin
		case (cd_end.quad)
			2'd0:    begin sv = cd_end.y;  cv = cd_end.x;  end
			2'd1:    begin sv = cd_end.x;  cv = -cd_end.y; end
			2'd2:    begin sv = -cd_end.y; cv = -cd_end.x; end
			default: begin sv = -cd_end.x; cv = cd_end.y;  end
		endcase
		svs = (sv > OneQ30) ? OneQ30 : ((sv < -OneQ30) ? -OneQ30 : sv);
		cvs = (cv > OneQ30) ? OneQ30 : ((cv < -OneQ30) ? -OneQ30 : cv);
	end

	logic             v_s5;
	logic             sneg_s5;
	logic [31:0]      sabs_s5;
	logic signed [31:0] cos_s5;
	logic [31:0]      r_s5;
	logic [2:0][31:0] mag_s5;
	logic [2:0]       neg_s5;
	logic             zero_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= cd_end.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s5 <= svs[35];
			sabs_s5 <= svs[35] ? 32'(-svs) : 32'(svs);
			cos_s5  <= 32'(cvs);
			r_s5    <= cd_end.r;
			mag_s5  <= cd_end.mag;
			neg_s5  <= cd_end.neg;
			zero_s5 <= cd_end.zero;
		end
	end

	// Products plus rounding bias feed the divider chain
	dv_tok_t dv_chain [0:DivBits];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_chain[0] <= '0;
		end else if (en) begin
			dv_chain[0].vld <= v_s5;
			for (int l = 0; l < 3; l++) begin
				dv_chain[0].num[l] <= 64'(mag_s5[l]) * 64'(sabs_s5) + 64'(r_s5 >> 1);
				dv_chain[0].neg[l] <= neg_s5[l] ^ sneg_s5;
			end
			dv_chain[0].quo  <= '0;
			dv_chain[0].r    <= r_s5;
			dv_chain[0].cosv <= cos_s5;
			dv_chain[0].zero <= zero_s5;
		end
	end

	for (genvar g = 0; g < DivBits; g++) begin : g_div
		rv2q_div_cell u_cell (
			.clk, .arst_n, .en,
			.bit_idx(5'(DivBits - 1 - g)),
			.tok_in(dv_chain[g]), .tok_out(dv_chain[g + 1])
		);
	end

	// Output register
	dv_tok_t dv_end;
	assign dv_end = dv_chain[DivBits];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_end.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_end.zero) begin
				out_q.quat_x <= '0;
				out_q.quat_y <= '0;
				out_q.quat_z <= '0;
				out_q.quat_w <= 32'sd1073741824;
			end else begin
				out_q.quat_x <= dv_end.neg[0] ? -dv_end.quo[0] : dv_end.quo[0];
				out_q.quat_y <= dv_end.neg[1] ? -dv_end.quo[1] : dv_end.quo[1];
				out_q.quat_z <= dv_end.neg[2] ? -dv_end.quo[2] : dv_end.quo[2];
				out_q.quat_w <= dv_end.cosv;
			end
		end
	end
	assign quat.valid = out_vld_q;
	assign quat.data  = out_q;
endmodule

>>> sv/rv2q_checker.sv
// ----------------------------------------------------------------------------
// rv2q_checker: port-level checks
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module rv2q_port_checks (
	input logic            clk,
	input logic            arst_n,
	input logic            rot_valid,
	input logic            rot_ready,
	input logic            quat_valid,
	input logic            quat_ready,
	input rv2q_pkg::quat_t quat_data
);
	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |=> quat_valid && $stable(quat_data))
		else $error("result changed while stalled");

	// Accept input whenever the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!quat_valid |-> rot_ready)
		else $error("input blocked with empty output");

	// Keep the scalar part of results inside the unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> quat_data.quat_w <= 32'sd1073741824
			&& quat_data.quat_w >= -32'sd1073741824)
		else $error("scalar part out of range");
endmodule

bind rotation_vector_to_quaternion rv2q_port_checks u_rv2q_checker (
	.clk, .arst_n,
	.rot_valid(rot.valid), .rot_ready(rot.ready),
	.quat_valid(quat.valid), .quat_ready(quat.ready),
	.quat_data(quat.data)
);
